### rtl/jcp_pkg.sv
// jcp_pkg: constants, register map and crc helper for the joystick packet block
`default_nettype none

package jcp_pkg;

  // converter sample width and the half scale used as full deflection
  localparam int AdcBits   = 12;
  localparam int HalfScale = ((1 << AdcBits) - 1) / 2;

  // stream and register port widths
  localparam int InWidth   = 24;
  localparam int OutWidth  = 48;
  localparam int AddrWidth = 5;

  // arithmetic constants
  localparam logic [16:0] QOne      = 17'h10000;
  localparam logic [16:0] PctScale  = 17'd100;
  localparam logic [33:0] RoundHalf = 34'h0_0000_8000;

  // crc16 ccitt, msb first
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // register reset values
  localparam logic [11:0] CenterReset   = 12'd2048;
  localparam logic [10:0] DeadBandReset = 11'd180;

  // register indexes (byte address is 4 * index)
  typedef enum logic [2:0] {
    RegCenterX     = 3'd0,
    RegCenterY     = 3'd1,
    RegDeadBand    = 3'd2,
    RegInvertSpeed = 3'd3,
    RegInvertSteer = 3'd4,
    RegCurveOn     = 3'd5
  } reg_idx_e;

  // one byte of crc, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/joystick_to_control_packet.sv
// joystick_to_control_packet: joystick samples to percent commands and a crc-protected packet
//
// Use: one word on the input stream carries raw_x in bits 11:0 and raw_y in bits 23:12.
// For each accepted word one word leaves on the output stream: speed_cmd, steer_cmd,
// flag_bits, sequence_res and check_word, packed from the low bits up.
// Both axes run one after the other through one shared subtractor (16 divide steps,
// then 16 square root steps) and one shared 17x17 multiplier, then six crc byte steps.
// Latency from the accepting edge to output valid is shortest when both axes sit in the
// dead band and longest when both axes need divide and curve; a new word is taken
// in the cycle after the result is loaded. The sequencer is the limit: the divide and
// square root loops take one bit per cycle.
// The input is not ready while an item is at work. The result sits in an output
// register, so the next word is accepted and processed while the receiver stalls;
// only the final load waits for the output register to free up.
// Reset clears the sequence number to zero and loads the register defaults
// (centers 2048, dead band 180, no inversion, curve on); no clearing pass is needed.
// Registers are written over apb; the user writes only while the block is idle (not enforced).
`default_nettype none

module joystick_to_control_packet (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input stream, tdata: raw_x[11:0], raw_y[23:12]
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [jcp_pkg::InWidth-1:0]   s_axis_tdata_i,
  // output stream, tdata: speed_cmd[7:0], steer_cmd[15:8], flag_bits[18:16],
  // sequence_res[26:19], check_word[42:27], zero fill[47:43]
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [jcp_pkg::OutWidth-1:0]       m_axis_tdata_o,
  // apb register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [jcp_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import jcp_pkg::*;

  typedef enum logic [9:0] {
    StIdle = 10'b00_0000_0001,
    StPrep = 10'b00_0000_0010,
    StDiv  = 10'b00_0000_0100,
    StXChk = 10'b00_0000_1000,
    StSqrt = 10'b00_0001_0000,
    StMulY = 10'b00_0010_0000,
    StMulP = 10'b00_0100_0000,
    StFin  = 10'b00_1000_0000,
    StCrc  = 10'b01_0000_0000,
    StDone = 10'b10_0000_0000
  } state_e;

  // configuration registers
  logic [11:0] center_x_q, center_y_q;
  logic [10:0] dead_band_q;
  logic        invert_speed_q, invert_steer_q, curve_on_q;

  // sequencer and datapath registers
  state_e      state_q, state_d;
  logic        axis_q, axis_d;
  logic        neg_q, neg_d;
  logic [19:0] rem_q, rem_d;
  logic [16:0] x_q, x_d;
  logic [15:0] root_q, root_d;
  logic [15:0] vsh_q, vsh_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [6:0]  p_q, p_d;
  logic [11:0] raw_x_q, raw_x_d, raw_y_q, raw_y_d;
  logic [7:0]  speed_q, speed_d, steer_q, steer_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  seq_q, seq_d;
  logic        out_vld_q, out_vld_d;
  logic [OutWidth-1:0] out_data_q, out_data_d;

  // combinational helpers
  logic [11:0] raw_sel, ctr_sel, mag, span;
  logic [12:0] diff13;
  logic        in_dead, sat, neg_eff, load_out;
  logic [19:0] sub_a, sub_b;
  logic [20:0] sub_diff;
  logic        sub_ge;
  logic [16:0] mul_b;
  logic [33:0] mul_p, rnd;
  logic [7:0]  pct_val, crc_in;
  logic [2:0]  flags;
  logic        wr_en;

  // apb register file
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q     <= CenterReset;
      center_y_q     <= CenterReset;
      dead_band_q    <= DeadBandReset;
      invert_speed_q <= 1'b0;
      invert_steer_q <= 1'b0;
      curve_on_q     <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        RegCenterX:     center_x_q     <= pwdata[11:0];
        RegCenterY:     center_y_q     <= pwdata[11:0];
        RegDeadBand:    dead_band_q    <= pwdata[10:0];
        RegInvertSpeed: invert_speed_q <= pwdata[0];
        RegInvertSteer: invert_steer_q <= pwdata[0];
        RegCurveOn:     curve_on_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    unique case (paddr[4:2])
      RegCenterX:     prdata = {20'd0, center_x_q};
      RegCenterY:     prdata = {20'd0, center_y_q};
      RegDeadBand:    prdata = {21'd0, dead_band_q};
      RegInvertSpeed: prdata = {31'd0, invert_speed_q};
      RegInvertSteer: prdata = {31'd0, invert_steer_q};
      RegCurveOn:     prdata = {31'd0, curve_on_q};
      default:        prdata = 32'd0;
    endcase
  end

  // axis offset, dead band and saturation checks
  assign raw_sel = axis_q ? raw_y_q : raw_x_q;
  assign ctr_sel = axis_q ? center_y_q : center_x_q;
  assign diff13  = {1'b0, raw_sel} - {1'b0, ctr_sel};
  assign mag     = diff13[12] ? 12'(13'(-diff13)) : diff13[11:0];
  assign span    = 12'(HalfScale) - {1'b0, dead_band_q};
  assign in_dead = mag <= {1'b0, dead_band_q};
  assign sat     = (span == 12'd0) || (mag >= span);

  // shared compare and subtract unit: divide step or square root step
  assign sub_a    = (state_q == StSqrt) ? {rem_q[17:0], vsh_q[15:14]} : {rem_q[18:0], 1'b0};
  assign sub_b    = (state_q == StSqrt) ? {2'b00, root_q, 2'b01} : {8'd0, span};
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_diff[20];

  // shared multiplier: curve product or percent scale
  assign mul_b = (state_q == StMulP) ? PctScale : {1'b0, root_q};
  assign mul_p = x_q * mul_b;
  assign rnd   = mul_p + RoundHalf;

  // sign restore: speed takes the negated x sign
  assign neg_eff = axis_q ? (neg_q ^ invert_steer_q) : (~neg_q ^ invert_speed_q);
  assign pct_val = neg_eff ? 8'(-{1'b0, p_q}) : {1'b0, p_q};

  // packet bytes in crc order
  assign flags = {curve_on_q, invert_steer_q, invert_speed_q};
  always_comb begin
    case (cnt_q[2:0])
      3'd0:    crc_in = speed_q;
      3'd1:    crc_in = {8{speed_q[7]}};
      3'd2:    crc_in = steer_q;
      3'd3:    crc_in = {8{steer_q[7]}};
      3'd4:    crc_in = {5'd0, flags};
      3'd5:    crc_in = seq_q;
      default: crc_in = 8'h00;
    endcase
  end

  assign load_out = (state_q == StDone) && (!out_vld_q || m_axis_tready_i);

  // sequencer
  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    neg_d      = neg_q;
    rem_d      = rem_q;
    x_d        = x_q;
    root_d     = root_q;
    vsh_d      = vsh_q;
    cnt_d      = cnt_q;
    p_d        = p_q;
    raw_x_d    = raw_x_q;
    raw_y_d    = raw_y_q;
    speed_d    = speed_q;
    steer_d    = steer_q;
    crc_d      = crc_q;
    seq_d      = seq_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          raw_x_d = s_axis_tdata_i[11:0];
          raw_y_d = s_axis_tdata_i[23:12];
          axis_d  = 1'b0;
          state_d = StPrep;
        end
      end
      StPrep: begin
        neg_d = diff13[12];
        rem_d = {8'd0, mag};
        cnt_d = 4'd0;
        x_d   = 17'd0;
        if (in_dead) begin
          p_d     = 7'd0;
          state_d = StFin;
        end else if (sat) begin
          x_d     = QOne;
          state_d = StXChk;
        end else begin
          state_d = StDiv;
        end
      end
      // one quotient bit per cycle
      StDiv: begin
        rem_d = sub_ge ? sub_diff[19:0] : sub_a;
        x_d   = {x_q[15:0], sub_ge};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = StXChk;
        end
      end
      // curve needed unless off or at full scale
      StXChk: begin
        rem_d  = 20'd0;
        root_d = 16'd0;
        vsh_d  = x_q[15:0];
        cnt_d  = 4'd0;
        state_d = (curve_on_q && (x_q != QOne)) ? StSqrt : StMulP;
      end
      // one root bit per cycle
      StSqrt: begin
        rem_d  = sub_ge ? sub_diff[19:0] : sub_a;
        root_d = {root_q[14:0], sub_ge};
        vsh_d  = {vsh_q[13:0], 2'b00};
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = StMulY;
        end
      end
      StMulY: begin
        x_d     = mul_p[32:16];
        state_d = StMulP;
      end
      StMulP: begin
        p_d     = rnd[22:16];
        state_d = StFin;
      end
      StFin: begin
        if (axis_q) begin
          steer_d = pct_val;
          crc_d   = CrcInit;
          cnt_d   = 4'd0;
          state_d = StCrc;
        end else begin
          speed_d = pct_val;
          axis_d  = 1'b1;
          state_d = StPrep;
        end
      end
      // one packet byte per cycle
      StCrc: begin
        crc_d = crc_byte(crc_q, crc_in);
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd5) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          out_data_d = {5'd0, crc_q, seq_q, flags, steer_q, speed_q};
          out_vld_d  = 1'b1;
          seq_d      = seq_q + 8'd1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      seq_q     <= 8'd0;
      out_vld_q <= 1'b0;
      axis_q    <= 1'b0;
      cnt_q     <= 4'd0;
    end else begin
      state_q   <= state_d;
      seq_q     <= seq_d;
      out_vld_q <= out_vld_d;
      axis_q    <= axis_d;
      cnt_q     <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    rem_q      <= rem_d;
    x_q        <= x_d;
    root_q     <= root_d;
    vsh_q      <= vsh_d;
    p_q        <= p_d;
    raw_x_q    <= raw_x_d;
    raw_y_q    <= raw_y_d;
    speed_q    <= speed_d;
    steer_q    <= steer_d;
    crc_q      <= crc_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // sequence number advances by one on each packet load
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (seq_q == 8'($past(seq_q) + 8'd1)))
    else $error("sequence number did not advance on load");

  // percent magnitude never exceeds full scale
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin) |-> (p_q <= 7'd100))
    else $error("percent magnitude out of range");

  // an accepted word starts the x axis
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> ((state_q == StPrep) && !axis_q))
    else $error("accepted word did not start the x axis");

  // a loaded packet is not overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("pending packet dropped");

endmodule

`default_nettype wire
